FILE: hdl/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising clock, off during reset.
`define ASSERT_SYNC(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

FILE: hdl/smm_pkg.sv
// Shared types, constants and helpers of the square matrix multiplier.
package smm_pkg;

   localparam int DATA_W       = 32;
   localparam int SIZE_W       = 4;
   localparam int IDX_W        = 3;
   localparam int MAX_SIZE_DEF = 8;
   localparam int OUT_DEPTH    = 4;
   localparam int JOB_DEPTH    = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

   typedef logic [SIZE_W-1:0] job_type;

   typedef struct packed {
      logic [DATA_W-1:0] c_elem;
      logic [IDX_W-1:0]  out_row;
      logic [IDX_W-1:0]  out_col;
      logic              last;
   } result_type;

   // Bookkeeping that travels with each read through the multiply pipeline.
   typedef struct packed {
      logic             first;
      logic             last_k;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             final_entry;
   } tag_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   function automatic int ptr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

FILE: hdl/smm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smm_ram import smm_pkg::*; #(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = MAX_SIZE_DEF * MAX_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ptr_width(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]            wr_data,
   input  logic [ptr_width(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/smm_fifo.sv
// Small first-in first-out queue built from registers.
module smm_fifo import smm_pkg::*; #(
   parameter int WIDTH = SIZE_W,
   parameter int DEPTH = JOB_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = ptr_width(DEPTH);
   localparam int CNT_W = ptr_width(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/smm_front.sv
// Load side: size register, element counter, store writes and job hand-off.
module smm_front import smm_pkg::*; #(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [SIZE_W-1:0]                       csr_write_data,
   input  logic                                    push,
   output logic                                    full,
   input  logic                                    job_empty,
   input  logic                                    back_busy,
   output logic                                    wr_en,
   output logic [ptr_width(MAX_SIZE*MAX_SIZE)-1:0] wr_addr,
   output logic                                    job_push,
   output job_type                                 job_size
);

   localparam int ADDR_W = ptr_width(MAX_SIZE * MAX_SIZE);
   localparam int TOT_W  = 2 * SIZE_W;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic [SIZE_W-1:0] eff_size;
   logic [TOT_W-1:0]  total;
   logic [TOT_W-1:0]  count_next;
   logic              accepted;
   logic              complete;

   // The register keeps the written bits; out-of-range sizes are clamped here.
   always_comb begin
      if (size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(MAX_SIZE)) begin
         eff_size = SIZE_W'(MAX_SIZE);
      end else begin
         eff_size = size_ff;
      end
   end

   assign total      = {{SIZE_W{1'b0}}, eff_size} * {{SIZE_W{1'b0}}, eff_size};
   assign count_next = TOT_W'(count_ff) + 1'b1;

   // Hold off new beats while a finished load waits or the stores are being read.
   assign full     = !job_empty || back_busy;
   assign accepted = push && !full;
   assign complete = accepted && (count_next == total);

   always_comb begin
      size_in  = size_ff;
      count_in = count_ff;
      if (csr_write_enable) begin
         size_in  = csr_write_data;
         count_in = '0;
      end else if (accepted) begin
         count_in = complete ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_RESET;
         count_ff <= '0;
      end else begin
         size_ff  <= size_in;
         count_ff <= count_in;
      end
   end

   assign wr_en    = accepted;
   assign wr_addr  = count_ff;
   assign job_push = complete;
   assign job_size = eff_size;

endmodule

FILE: hdl/smm_back.sv
// Compute side: walks row, column and inner index through one shared multiply-accumulate.
module smm_back import smm_pkg::*; #(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    job_empty,
   input  job_type                                 job_size,
   output logic                                    job_pop,
   output logic                                    busy,
   output logic [ptr_width(MAX_SIZE*MAX_SIZE)-1:0] rd_addr_a,
   output logic [ptr_width(MAX_SIZE*MAX_SIZE)-1:0] rd_addr_b,
   input  logic [DATA_W-1:0]                       a_data,
   input  logic [DATA_W-1:0]                       b_data,
   input  logic                                    rsp_taken,
   output logic                                    out_push,
   output result_type                              out_data
);

   localparam int ADDR_W = ptr_width(MAX_SIZE * MAX_SIZE);
   localparam int CRED_W = ptr_width(OUT_DEPTH + 1);

   back_state_type    state_ff, state_in;
   logic [SIZE_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0]  r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [ADDR_W-1:0] a_base_ff, a_base_in, b_addr_ff, b_addr_in;
   logic [CRED_W-1:0] credit_ff, credit_in;
   logic              v1_ff, v2_ff;
   tag_type           tag1_ff, tag1_in, tag2_ff;
   logic [DATA_W-1:0] prod_ff, acc_ff, acc_in, sum;
   logic [SIZE_W-1:0] n_last;
   logic              last_k, last_c, last_r, last_all;
   logic              issue, start;

   assign n_last   = n_ff - 1'b1;
   assign last_k   = (SIZE_W'(k_ff) == n_last);
   assign last_c   = (SIZE_W'(c_ff) == n_last);
   assign last_r   = (SIZE_W'(r_ff) == n_last);
   assign last_all = last_k && last_c && last_r;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!job_empty) begin
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (issue && last_all) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // A new entry starts only with an output slot reserved for its result.
   always_comb begin
      job_pop = 1'b0;
      busy    = 1'b0;
      issue   = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            job_pop = !job_empty;
         end
         BACK_RUN: begin
            busy  = 1'b1;
            issue = (k_ff != '0) || (credit_ff < CRED_W'(OUT_DEPTH));
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   assign start = issue && (k_ff == '0);

   always_comb begin
      n_in      = n_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      a_base_in = a_base_ff;
      b_addr_in = b_addr_ff;
      if (job_pop) begin
         n_in      = job_size;
         r_in      = '0;
         c_in      = '0;
         k_in      = '0;
         a_base_in = '0;
         b_addr_in = '0;
      end else if (issue) begin
         if (!last_k) begin
            k_in      = k_ff + 1'b1;
            b_addr_in = b_addr_ff + ADDR_W'(n_ff);
         end else begin
            k_in = '0;
            if (!last_c) begin
               c_in      = c_ff + 1'b1;
               b_addr_in = ADDR_W'(c_ff) + 1'b1;
            end else begin
               c_in      = '0;
               b_addr_in = '0;
               r_in      = r_ff + 1'b1;
               a_base_in = a_base_ff + ADDR_W'(n_ff);
            end
         end
      end
   end

   assign rd_addr_a = a_base_ff + ADDR_W'(k_ff);
   assign rd_addr_b = b_addr_ff;

   always_comb begin
      tag1_in.first       = (k_ff == '0);
      tag1_in.last_k      = last_k;
      tag1_in.row         = r_ff;
      tag1_in.col         = c_ff;
      tag1_in.final_entry = last_all;
   end

   always_comb begin
      case ({start, rsp_taken})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   // Only the low word of each product and of the sum is ever visible.
   assign sum    = tag2_ff.first ? prod_ff : acc_ff + prod_ff;
   assign acc_in = v2_ff ? sum : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_IDLE;
         credit_ff <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         n_ff      <= SIZE_RESET;
         r_ff      <= '0;
         c_ff      <= '0;
         k_ff      <= '0;
         a_base_ff <= '0;
         b_addr_ff <= '0;
      end else begin
         state_ff  <= state_in;
         credit_ff <= credit_in;
         v1_ff     <= issue;
         v2_ff     <= v1_ff;
         n_ff      <= n_in;
         r_ff      <= r_in;
         c_ff      <= c_in;
         k_ff      <= k_in;
         a_base_ff <= a_base_in;
         b_addr_ff <= b_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= tag1_in;
      tag2_ff <= tag1_ff;
      prod_ff <= DATA_W'(a_data * b_data);
      acc_ff  <= acc_in;
   end

   assign out_push         = v2_ff && tag2_ff.last_k;
   assign out_data.c_elem  = sum;
   assign out_data.out_row = tag2_ff.row;
   assign out_data.out_col = tag2_ff.col;
   assign out_data.last    = tag2_ff.final_entry;

endmodule

FILE: hdl/square_matrix_multiply.sv
// Square matrix multiplier top level: load front, job queue, compute back, result queue.
//
// Write the size n (1 to MAX_SIZE; 0 reads as 1, larger values as MAX_SIZE) through
// csr_write_data while the block is idle; a write also discards any partial load.
// Push n*n beats, each one element of A and the element of B at the same place,
// row-major, one beat per cycle. After the last beat full stays high while the
// job is handed over and then while the product is formed: one shared 32x32
// multiply-accumulate takes one product per cycle while an output slot can be
// reserved, and each entry passes the store read and product registers before
// it is pushed into the result queue. Entries leave through a four-deep result
// queue in row-major order, low 32 bits of each sum, with rsp_last on the final
// one; a slow consumer stalls the multiplier. The element stores need no
// clearing after reset.
`include "assert_macros.svh"

module square_matrix_multiply import smm_pkg::*; #(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [SIZE_W-1:0]        csr_write_data,
   input  logic                     push,
   output logic                     full,
   input  logic signed [DATA_W-1:0] req_a_elem,
   input  logic signed [DATA_W-1:0] req_b_elem,
   output logic                     empty,
   input  logic                     pop,
   output logic signed [DATA_W-1:0] rsp_c_elem,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic                     rsp_last
);

   localparam int CELLS  = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W = ptr_width(CELLS);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0] a_data, b_data;
   logic              job_push, job_pop, job_empty, job_full;
   job_type           job_size_in, job_size_out;
   logic              back_busy;
   logic              out_push, out_full;
   result_type        out_data, rsp_data;
   logic              rsp_taken;

   assign rsp_taken = pop && !empty;

   smm_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .full             (full),
      .job_empty        (job_empty),
      .back_busy        (back_busy),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .job_push         (job_push),
      .job_size         (job_size_in)
   );

   smm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CELLS)
   ) u_left_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_a_elem),
      .rd_addr (rd_addr_a),
      .rd_data (a_data)
   );

   smm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CELLS)
   ) u_right_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_b_elem),
      .rd_addr (rd_addr_b),
      .rd_data (b_data)
   );

   smm_fifo #(
      .WIDTH (SIZE_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_size_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_size_out),
      .empty     (job_empty)
   );

   smm_back #(
      .MAX_SIZE (MAX_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_size  (job_size_out),
      .job_pop   (job_pop),
      .busy      (back_busy),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .a_data    (a_data),
      .b_data    (b_data),
      .rsp_taken (rsp_taken),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   smm_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

   assign rsp_c_elem  = rsp_data.c_elem;
   assign rsp_out_row = rsp_data.out_row;
   assign rsp_out_col = rsp_data.out_col;
   assign rsp_last    = rsp_data.last;

   // A finished load is handed over only when nothing else is queued or being read.
   `ASSERT_SYNC(a_job_alone, job_push |-> (job_empty && !back_busy && !job_full), "job overlap")
   // The output slot reservation must keep the result queue from overflowing.
   `ASSERT_NEVER(a_no_result_overflow, out_push && out_full, "result queue overflow")
   // The final entry sits on the diagonal.
   `ASSERT_SYNC(a_last_diag, (!empty && rsp_last) |-> (rsp_out_row == rsp_out_col), "last off diagonal")

endmodule
